// ----- rtl/cusum_drift_hunt_tracker_assert.svh -----
// Assertion macros shared by the drift tracker RTL.
`ifndef CUSUM_DRIFT_HUNT_TRACKER_ASSERT_SVH
`define CUSUM_DRIFT_HUNT_TRACKER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and disabled during reset.
`define CDHT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("drift tracker assertion failed");

// Next-cycle implication, sampled on i_clk and disabled during reset.
`define CDHT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("drift tracker assertion failed");

`endif

// ----- rtl/cdht_pkg.sv -----
// Types and constants of the CUSUM drift and hunt tracker.
package cdht_pkg;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_BAND      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_LEVEL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAG_FRACTION   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE_FRACTION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_INTERVAL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_MINUTES  = 3'd5;

    // Register reset values.
    localparam logic [30:0] HALF_BAND_RST      = 31'd65536;
    localparam logic [30:0] WARN_LEVEL_RST     = 31'd655360;
    localparam logic [16:0] LAG_FRACTION_RST   = 17'd32768;
    localparam logic [16:0] STALE_FRACTION_RST = 17'd6554;
    localparam logic [15:0] RESET_INTERVAL_RST = 16'd100;
    localparam logic [23:0] CYCLE_MINUTES_RST  = 24'd65536;

    // Flag bit positions.
    localparam int FLAG_RISE = 0;
    localparam int FLAG_FALL = 1;
    localparam int FLAG_HUNT = 2;

    typedef struct packed {
        logic signed [31:0] observed;
        logic signed [31:0] guide;
        logic               valid_req;
        logic               steady;
    } t_in_item;

    typedef struct packed {
        logic               rising;
        logic               falling;
        logic               hunting;
        logic        [30:0] pos_sum;
        logic signed [31:0] neg_sum;
        logic               updated;
    } t_out_item;

endpackage

// ----- rtl/cusum_drift_hunt_tracker.sv -----
// Top level of the CUSUM drift and hunt tracker.
//
// Usage: each input transfer carries one sensor cycle (observed value, guide
// value, a validity bit and a steady bit) and produces exactly one result
// transfer with the rising, falling and hunting flags and both accumulators.
// Both channels use valid and stall; a transfer happens on a rising edge with
// valid high and stall low.
//
// An input transfer is registered in stage one, then in the result register,
// before its result is offered. The first stage forms the two band areas (one
// multiply each by the cycle length) and saturates them; the second stage
// decays or adds into the accumulators, clamps them and derives the flags. The
// accumulator feedback closes in stage two; one item per cycle when not stalled.
//
// When the receiver stalls, the result register holds its transfer, the first
// stage fills, and then o_in_stall rises in the same cycle, so no item is lost.
// Reset (synchronous, active low) loads the register defaults, clears both
// accumulators, the application count and all flags, and empties the pipe.
// Configuration writes are registered, the lag limit from them once more; they
// must be made while no item is in flight, which the block does not enforce.
module cusum_drift_hunt_tracker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  cdht_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output cdht_pkg::t_out_item               o_out_item,
    input  logic                              i_cfg_we,
    input  logic [cdht_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cdht_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import cdht_pkg::*;

    // Saturate a non-negative area quotient; anything at or above 2^31 already
    // drives an accumulator past any warn level.
    function automatic logic [31:0] sat_area(input logic [42:0] q);
        logic [31:0] res;
        if (q[42:31] != 12'd0) begin
            res = 32'h8000_0000;
        end else begin
            res = {1'b0, q[30:0]};
        end
        return res;
    endfunction

    // One accumulator magnitude step: add fresh area or decay, then clamp.
    function automatic logic [30:0] step_acc(input logic [30:0] base,
                                             input logic        hit,
                                             input logic [31:0] area,
                                             input logic [16:0] stale,
                                             input logic [30:0] warn);
        logic [32:0] sum;
        logic [47:0] dprod;
        logic [31:0] dec;
        logic [30:0] res;
        if (hit) begin
            sum = {2'b00, base} + {1'b0, area};
        end else begin
            dprod = base * stale;
            dec   = dprod[47:16];
            if ({1'b0, base} >= dec) begin
                sum = {2'b00, base - dec[30:0]};
            end else begin
                sum = 33'd0;
            end
        end
        if (sum > {2'b00, warn}) begin
            res = warn;
        end else begin
            res = sum[30:0];
        end
        return res;
    endfunction

    // Configuration registers.
    logic [30:0] r_half_band;
    logic [30:0] r_warn_level;
    logic [16:0] r_lag_fraction;
    logic [16:0] r_stale_fraction;
    logic [15:0] r_reset_interval;
    logic [23:0] r_cycle_minutes;
    logic [47:0] r_lag_lim;

    // Tracker state; the negative accumulator is kept as its magnitude.
    logic [30:0] r_pos_acc;
    logic [30:0] r_neg_mag;
    logic [15:0] r_apps_count;
    logic [2:0]  r_flags_now;
    logic [2:0]  r_flags_before;

    // Stage one: saturated band areas and item control bits.
    logic        r_s1_valid;
    logic        r_s1_valid_req;
    logic        r_s1_steady;
    logic        r_s1_top_hit;
    logic        r_s1_btm_hit;
    logic [31:0] r_s1_top_area;
    logic [31:0] r_s1_btm_area;

    // Result register.
    logic        r_out_valid;
    t_out_item   r_out;

    logic               out_free;
    logic               s1_adv;
    logic               in_take;
    logic signed [33:0] diff_top;
    logic signed [33:0] diff_btm;
    logic signed [58:0] prod_top;
    logic signed [58:0] prod_btm;
    logic signed [58:0] neg_prod_btm;
    logic               n_top_hit;
    logic               n_btm_hit;
    logic [31:0]        n_top_area;
    logic [31:0]        n_btm_area;

    logic [16:0] next_apps;
    logic        clear_now;
    logic [30:0] base_pos;
    logic [30:0] base_neg;
    logic [30:0] chart_pos;
    logic [30:0] chart_neg;
    logic [2:0]  chart_flags;
    logic [30:0] n_pos_acc;
    logic [30:0] n_neg_mag;
    logic [15:0] n_apps_count;
    logic [2:0]  n_flags_now;
    logic [2:0]  n_flags_before;
    logic        n_updated;
    t_out_item   n_out;

    // Handshake: the result register frees when it is empty or being taken.
    assign out_free    = !r_out_valid || !i_out_stall;
    assign s1_adv      = r_s1_valid && out_free;
    assign o_in_stall  = r_s1_valid && !out_free;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Band areas, scaled by the cycle length in Q8.16 minutes. Truncation
    // toward zero means an area counts only when its product reaches 2^16.
    always_comb begin
        diff_top     = 34'(i_in_item.observed) - 34'(i_in_item.guide)
                       - $signed({3'b000, r_half_band});
        diff_btm     = 34'(i_in_item.observed) - 34'(i_in_item.guide)
                       + $signed({3'b000, r_half_band});
        prod_top     = diff_top * $signed({1'b0, r_cycle_minutes});
        prod_btm     = diff_btm * $signed({1'b0, r_cycle_minutes});
        neg_prod_btm = -prod_btm;
        n_top_hit    = !prod_top[58] && (prod_top[57:16] != 42'd0);
        n_btm_hit    = prod_btm[58] && (neg_prod_btm[57:16] != 42'd0);
        n_top_area   = sat_area(prod_top[58:16]);
        n_btm_area   = sat_area(neg_prod_btm[58:16]);
    end

    // Chart update for the item leaving stage one.
    always_comb begin
        next_apps = {1'b0, r_apps_count} + 17'd1;
        clear_now = next_apps > {1'b0, r_reset_interval};
        base_pos  = clear_now ? 31'd0 : r_pos_acc;
        base_neg  = clear_now ? 31'd0 : r_neg_mag;
        chart_pos = step_acc(base_pos, r_s1_top_hit, r_s1_top_area,
                             r_stale_fraction, r_warn_level);
        chart_neg = step_acc(base_neg, r_s1_btm_hit, r_s1_btm_area,
                             r_stale_fraction, r_warn_level);

        chart_flags = 3'b000;
        chart_flags[FLAG_RISE] = (chart_pos == r_warn_level)
                                 && !({1'b0, chart_neg, 16'd0} > r_lag_lim);
        chart_flags[FLAG_FALL] = (chart_neg == r_warn_level)
                                 && !({1'b0, chart_pos, 16'd0} > r_lag_lim);
        chart_flags[FLAG_HUNT] = (chart_pos == r_warn_level)
                                 && (chart_neg == r_warn_level);

        n_pos_acc      = r_pos_acc;
        n_neg_mag      = r_neg_mag;
        n_apps_count   = r_apps_count;
        n_flags_now    = r_flags_now;
        n_flags_before = r_flags_before;
        n_updated      = 1'b0;
        if (!r_s1_valid_req) begin
            // An invalid cycle backs the flags out to their earlier values.
            n_flags_now = r_flags_before;
        end else begin
            n_flags_before = r_flags_now;
            if (r_s1_steady) begin
                n_pos_acc    = chart_pos;
                n_neg_mag    = chart_neg;
                n_apps_count = clear_now ? 16'd0 : next_apps[15:0];
                n_flags_now  = chart_flags;
                n_updated    = 1'b1;
            end
        end

        n_out.rising  = n_flags_now[FLAG_RISE];
        n_out.falling = n_flags_now[FLAG_FALL];
        n_out.hunting = n_flags_now[FLAG_HUNT];
        n_out.pos_sum = n_pos_acc;
        n_out.neg_sum = 32'd0 - {1'b0, n_neg_mag};
        n_out.updated = n_updated;
    end

    // Configuration registers and the precomputed lag limit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_band      <= HALF_BAND_RST;
            r_warn_level     <= WARN_LEVEL_RST;
            r_lag_fraction   <= LAG_FRACTION_RST;
            r_stale_fraction <= STALE_FRACTION_RST;
            r_reset_interval <= RESET_INTERVAL_RST;
            r_cycle_minutes  <= CYCLE_MINUTES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HALF_BAND:      r_half_band      <= i_cfg_data;
                CFG_WARN_LEVEL:     r_warn_level     <= i_cfg_data;
                CFG_LAG_FRACTION:   r_lag_fraction   <= i_cfg_data[16:0];
                CFG_STALE_FRACTION: r_stale_fraction <= i_cfg_data[16:0];
                CFG_RESET_INTERVAL: r_reset_interval <= i_cfg_data[15:0];
                CFG_CYCLE_MINUTES:  r_cycle_minutes  <= i_cfg_data[23:0];
                default: begin
                end
            endcase
        end
        r_lag_lim <= r_lag_fraction * r_warn_level;
    end

    // Pipeline control and tracker state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_pos_acc      <= 31'd0;
            r_neg_mag      <= 31'd0;
            r_apps_count   <= 16'd0;
            r_flags_now    <= 3'b000;
            r_flags_before <= 3'b000;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid    <= 1'b1;
                r_pos_acc      <= n_pos_acc;
                r_neg_mag      <= n_neg_mag;
                r_apps_count   <= n_apps_count;
                r_flags_now    <= n_flags_now;
                r_flags_before <= n_flags_before;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_valid_req <= i_in_item.valid_req;
            r_s1_steady    <= i_in_item.steady;
            r_s1_top_hit   <= n_top_hit;
            r_s1_btm_hit   <= n_btm_hit;
            r_s1_top_area  <= n_top_area;
            r_s1_btm_area  <= n_btm_area;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

`include "cusum_drift_hunt_tracker_assert.svh"

    // The offered result always mirrors the accumulator state.
    `CDHT_ASSERT_IMPL(a_out_matches_pos, r_out_valid, r_out.pos_sum == r_pos_acc)
    // Hunting after an update means both sums sit at the same magnitude.
    `CDHT_ASSERT_IMPL(a_hunt_symmetric, r_out_valid && r_out.updated && r_out.hunting,
        {1'b0, r_out.pos_sum} == (32'd0 - r_out.neg_sum))
    // Input stalls only when both stages hold an item.
    `CDHT_ASSERT_IMPL(a_stall_only_full, o_in_stall, r_s1_valid && r_out_valid)
    // An item that may move on reaches the result register next cycle.
    `CDHT_ASSERT_NEXT(a_s1_moves_on, r_s1_valid && !(r_out_valid && i_out_stall),
        r_out_valid)

endmodule

// ----- sim/cdht_checker.sv -----
// Checker for the drift tracker: tracks accumulators and flags, compares every result transfer.
module cdht_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  cdht_pkg::t_in_item                i_in_item,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  cdht_pkg::t_out_item               i_out_item,
    input  logic                              i_cfg_we,
    input  logic [cdht_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cdht_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending
);
    import cdht_pkg::*;

    // Register copies, updated from the write port as the block sees them.
    logic [30:0] band_half;
    logic [30:0] warn_cap;
    logic [16:0] lag_frac;
    logic [16:0] decay_frac;
    logic [15:0] clear_interval;
    logic [23:0] minutes_per_cycle;

    // Tracker state.
    longint      pos_track;
    longint      neg_track;
    logic [15:0] app_count;
    logic [2:0]  flags_live;
    logic [2:0]  flags_prev;

    t_out_item   result_q[$];
    int          fail_total = 0;

    assign o_fail_count = fail_total;

    // Division by 2^16 that truncates toward zero.
    function automatic longint trunc_q16(input longint x);
        if (x < 0)
            return -((-x) >>> 16);
        return x >>> 16;
    endfunction

    task automatic advance_tracker(input t_in_item it, output t_out_item res);
        longint      obs;
        longint      gd;
        longint      band;
        longint      warn;
        longint      mins;
        longint      decay;
        longint      top_area;
        longint      btm_area;
        longint      lag_lim;
        longint      p;
        longint      n;
        logic [16:0] next_count;
        logic [2:0]  f;
        obs   = $signed(it.observed);
        gd    = $signed(it.guide);
        band  = longint'(band_half);
        warn  = longint'(warn_cap);
        mins  = longint'(minutes_per_cycle);
        decay = longint'(decay_frac);
        res.updated = 1'b0;
        if (!it.valid_req) begin
            flags_live = flags_prev;
        end else begin
            flags_prev = flags_live;
            if (it.steady) begin
                next_count = {1'b0, app_count} + 17'd1;
                if (next_count > {1'b0, clear_interval}) begin
                    pos_track = 0;
                    neg_track = 0;
                    app_count = '0;
                end else begin
                    app_count = next_count[15:0];
                end
                top_area = trunc_q16((obs - (gd + band)) * mins);
                btm_area = trunc_q16((obs - (gd - band)) * mins);
                p = pos_track;
                if (top_area > 0)
                    p = p + top_area;
                else
                    p = p - trunc_q16(pos_track * decay);
                n = neg_track;
                if (btm_area < 0)
                    n = n + btm_area;
                else
                    n = n + trunc_q16((-neg_track) * decay);
                if (p > warn) p = warn;
                if (p < 0) p = 0;
                if (n < -warn) n = -warn;
                if (n > 0) n = 0;
                pos_track = p;
                neg_track = n;
                lag_lim = longint'(lag_frac) * warn;
                f = '0;
                if (p == warn && !(n * 65536 < -lag_lim)) f[FLAG_RISE] = 1'b1;
                if (n == -warn && !(p * 65536 > lag_lim)) f[FLAG_FALL] = 1'b1;
                if (p == warn && n == -warn) f[FLAG_HUNT] = 1'b1;
                flags_live = f;
                res.updated = 1'b1;
            end
        end
        res.rising  = flags_live[FLAG_RISE];
        res.falling = flags_live[FLAG_FALL];
        res.hunting = flags_live[FLAG_HUNT];
        res.pos_sum = pos_track[30:0];
        res.neg_sum = neg_track[31:0];
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            band_half         = HALF_BAND_RST;
            warn_cap          = WARN_LEVEL_RST;
            lag_frac          = LAG_FRACTION_RST;
            decay_frac        = STALE_FRACTION_RST;
            clear_interval    = RESET_INTERVAL_RST;
            minutes_per_cycle = CYCLE_MINUTES_RST;
            pos_track  = 0;
            neg_track  = 0;
            app_count  = '0;
            flags_live = '0;
            flags_prev = '0;
            result_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("unexpected result: r%b f%b h%b pos %h neg %h upd %b",
                                 i_out_item.rising, i_out_item.falling, i_out_item.hunting,
                                 i_out_item.pos_sum, i_out_item.neg_sum, i_out_item.updated);
                end else begin
                    want = result_q.pop_front();
                    if (i_out_item.rising  !== want.rising  ||
                        i_out_item.falling !== want.falling ||
                        i_out_item.hunting !== want.hunting ||
                        i_out_item.pos_sum !== want.pos_sum ||
                        i_out_item.neg_sum !== want.neg_sum ||
                        i_out_item.updated !== want.updated) begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display({"mismatch: expected r%b f%b h%b pos %h neg %h upd %b, ",
                                      "got r%b f%b h%b pos %h neg %h upd %b"},
                                     want.rising, want.falling, want.hunting,
                                     want.pos_sum, want.neg_sum, want.updated,
                                     i_out_item.rising, i_out_item.falling,
                                     i_out_item.hunting, i_out_item.pos_sum,
                                     i_out_item.neg_sum, i_out_item.updated);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                advance_tracker(i_in_item, want);
                result_q = {result_q, want};
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HALF_BAND:      band_half         = i_cfg_data[30:0];
                    CFG_WARN_LEVEL:     warn_cap          = i_cfg_data[30:0];
                    CFG_LAG_FRACTION:   lag_frac          = i_cfg_data[16:0];
                    CFG_STALE_FRACTION: decay_frac        = i_cfg_data[16:0];
                    CFG_RESET_INTERVAL: clear_interval    = i_cfg_data[15:0];
                    CFG_CYCLE_MINUTES:  minutes_per_cycle = i_cfg_data[23:0];
                    default: ;
                endcase
            end
        end
        o_pending <= result_q.size();
    end

endmodule

// ----- sim/cusum_drift_hunt_tracker_test.sv -----
// Testbench top for the drift tracker: stimulus, stall pattern and final verdict.
module cusum_drift_hunt_tracker_test;
    import cdht_pkg::*;

    // Far above the length of the slowest correct run.
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
    localparam logic [31:0] MAX_S32 = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN_S32 = 32'h8000_0000;

    // Shapes of random traffic: full-range noise, steady drift up or down,
    // swings across the band in both directions, and small in-band noise.
    typedef enum int {MIX_WILD, MIX_UP, MIX_DOWN, MIX_SWING, MIX_QUIET} t_mix;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_HALF_BAND;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending;

    // Set while neither side may idle.
    bit quiet = 1'b0;
    // Asks the receiver for one long hold-off.
    bit hold_request = 1'b0;

    cusum_drift_hunt_tracker i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    cdht_checker i_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The receiver stalls at random in about 9 percent of cycles. On request it
    // holds off without a break, which lets the pipe fill up and pushes the
    // stall back onto the input side.
    initial begin : receiver
        int hold_left;
        bit stall_next;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                stall_next = 1'b1;
                hold_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = 299;
                stall_next = 1'b1;
            end else begin
                stall_next = !quiet && ($urandom_range(0, 99) < 9);
            end
            out_stall <= stall_next;
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic t_in_item make_item(input logic [31:0] obs, input logic [31:0] gd,
                                           input logic valid_req, input logic steady);
        t_in_item it;
        it.observed  = obs;
        it.guide     = gd;
        it.valid_req = valid_req;
        it.steady    = steady;
        return it;
    endfunction

    // Random item of the given shape. The offset from the guide is built from
    // the current half band, so drift items land just outside it and quiet
    // items mostly inside. Sums wrap at 32 bits, which is still a legal item.
    function automatic t_in_item random_item(input t_mix mix, input logic [30:0] hb);
        t_in_item           it;
        logic signed [31:0] base;
        logic [31:0]        offset;
        logic [31:0]        step;
        base = $urandom();
        base = base >>> $urandom_range(8, 31);
        step = $urandom_range(32'h0000_8000, 32'h0006_0000);
        it.valid_req = ($urandom_range(0, 99) < 92);
        it.steady    = ($urandom_range(0, 99) < 88);
        case (mix)
            MIX_UP:    offset = {1'b0, hb} + step;
            MIX_DOWN:  offset = -({1'b0, hb} + step);
            MIX_SWING: begin
                offset = {1'b0, hb} + step;
                if ($urandom_range(0, 1) == 1)
                    offset = -offset;
            end
            MIX_QUIET: offset = $urandom_range(0, {hb, 1'b0}) - {1'b0, hb};
            default:   offset = 32'h0;
        endcase
        if (mix == MIX_WILD) begin
            it.observed = $urandom();
            it.guide    = $urandom();
        end else begin
            it.guide    = base;
            it.observed = base + offset;
        end
        return it;
    endfunction

    // Offers one item and returns at the edge where it transfers. The payload
    // stays put while stalled. Afterwards the sender may take a short break.
    task automatic push_item(input t_in_item it);
        in_item  <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        if (!quiet && $urandom_range(0, 99) < 9) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic run_phase(input int count, input logic [30:0] hb);
        t_mix mix;
        mix = MIX_QUIET;
        for (int k = 0; k < count; k++) begin
            if (k % 40 == 0)
                mix = t_mix'($urandom_range(0, 4));
            push_item(random_item(mix, hb));
        end
    endtask

    // Stops offering and waits until every result has come back, then idles
    // so that the two-stage pipe can go quiet.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // Writes all six registers back to back; the enable drops after the last.
    task automatic write_settings(input logic [30:0] hb, input logic [30:0] warn,
                                  input logic [16:0] lag, input logic [16:0] stale,
                                  input logic [15:0] interval, input logic [23:0] minutes);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HALF_BAND;
        cfg_data  <= hb;
        @(posedge clk);
        cfg_index <= CFG_WARN_LEVEL;
        cfg_data  <= warn;
        @(posedge clk);
        cfg_index <= CFG_LAG_FRACTION;
        cfg_data  <= CFG_DATA_W'(lag);
        @(posedge clk);
        cfg_index <= CFG_STALE_FRACTION;
        cfg_data  <= CFG_DATA_W'(stale);
        @(posedge clk);
        cfg_index <= CFG_RESET_INTERVAL;
        cfg_data  <= CFG_DATA_W'(interval);
        @(posedge clk);
        cfg_index <= CFG_CYCLE_MINUTES;
        cfg_data  <= CFG_DATA_W'(minutes);
        @(posedge clk);
        cfg_we <= 1'b0;
        repeat (2) @(posedge clk);
    endtask

    initial begin : stimulus
        logic [30:0] hb;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed items under the reset settings: band of one unit, warn of ten.
        push_item(make_item(32'h0, 32'h0, 1'b1, 1'b1));
        // Largest positive area: the positive accumulator saturates at once.
        push_item(make_item(MAX_S32, MIN_S32, 1'b1, 1'b1));
        // An invalid item brings back the flags from before the last update.
        push_item(make_item(32'h0, 32'h0, 1'b0, 1'b1));
        // Valid but not steady: everything holds.
        push_item(make_item(32'h0, 32'h0, 1'b1, 1'b0));
        // Largest negative area while the positive side decays.
        push_item(make_item(MIN_S32, MAX_S32, 1'b1, 1'b1));
        push_item(make_item(MAX_S32, MAX_S32, 1'b1, 1'b1));
        push_item(make_item(MIN_S32, MIN_S32, 1'b1, 1'b1));
        // Exactly on either edge of the band, then one LSB beyond each edge.
        push_item(make_item(ONE_Q16, 32'h0, 1'b1, 1'b1));
        push_item(make_item(-ONE_Q16, 32'h0, 1'b1, 1'b1));
        push_item(make_item(ONE_Q16 + 32'd1, 32'h0, 1'b1, 1'b1));
        push_item(make_item(-ONE_Q16 - 32'd1, 32'h0, 1'b1, 1'b1));
        // Steady climb to the warn level.
        repeat (4) push_item(make_item(ONE_Q16 * 5, 32'h0, 1'b1, 1'b1));
        push_item(make_item(32'h0, 32'h0, 1'b0, 1'b0));
        push_item(make_item(32'h0, 32'h0, 1'b1, 1'b1));
        // Fall to minus warn, then swing back up.
        repeat (2) push_item(make_item(-(ONE_Q16 * 20), ONE_Q16, 1'b1, 1'b1));
        push_item(make_item(ONE_Q16 * 20, -ONE_Q16, 1'b1, 1'b1));
        push_item(make_item(32'h0, 32'h0, 1'b0, 1'b1));
        push_item(make_item(32'h0, 32'h0, 1'b0, 1'b1));
        run_phase(300, HALF_BAND_RST);
        drain();

        // Every register at its top value except the two fractions, set to one.
        write_settings(31'h7FFF_FFFF, 31'h7FFF_FFFF, 17'd65536, 17'd65536,
                       16'hFFFF, 24'hFF_FFFF);
        push_item(make_item(MAX_S32, MIN_S32, 1'b1, 1'b1));
        push_item(make_item(MIN_S32, MAX_S32, 1'b1, 1'b1));
        push_item(make_item(MAX_S32, MIN_S32, 1'b1, 1'b1));
        run_phase(250, 31'h7FFF_FFFF);
        drain();

        // Zero warn level: both accumulators pinned, all flags on every update.
        write_settings(31'h0002_0000, 31'h0, 17'd32768, 17'd6554, 16'd100, 24'h01_0000);
        run_phase(200, 31'h0002_0000);
        drain();

        // Fractions above one, short clear interval, and no idling on either side.
        quiet = 1'b1;
        write_settings(31'h0000_8000, 31'h0010_0000, 17'h1FFFF, 17'h1FFFF, 16'd7,
                       24'h01_0000);
        run_phase(250, 31'h0000_8000);
        drain();
        quiet = 1'b0;

        // Zero cycle length, zero band, zero fractions, clear on every update.
        write_settings(31'h0, 31'h000A_0000, 17'd0, 17'd0, 16'd0, 24'h0);
        run_phase(100, 31'h0);
        drain();

        // No decay and a low warn level make hunting reachable. The receiver
        // holds off for a long stretch at the start while items keep coming.
        write_settings(31'h0001_0000, 31'h0004_0000, 17'd65536, 17'd0, 16'hFFFF,
                       24'h01_0000);
        hold_request = 1'b1;
        run_phase(400, 31'h0001_0000);
        drain();

        // Random settings around the useful range.
        repeat (3) begin
            hb = 31'($urandom_range(0, 32'h0004_0000));
            write_settings(hb, 31'($urandom_range(0, 32'h0040_0000)),
                           17'($urandom_range(0, 131071)),
                           17'($urandom_range(0, 16384)), 16'($urandom_range(0, 200)),
                           24'($urandom_range(0, 32'h0004_0000)));
            run_phase(200, hb);
            drain();
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
